// File: design/ss_pkg.sv
// shared constants and types for the substring search core
package ss_pkg;

   localparam int PATTERN_MAX   = 16;
   localparam int POSITION_BITS = 16;

   localparam int CHAR_BITS     = 8;
   localparam int PATTERN_BITS  = 64;
   localparam int PLEN_BITS     = 5;
   localparam int OUT_POS_BITS  = 16;
   localparam int CSR_IDX_BITS  = 2;

   localparam int LEN_BITS      = $clog2(PATTERN_MAX + 1);
   localparam int IDX_BITS      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int HIST_DEPTH    = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
   localparam int POS_EXT_BITS  = (POSITION_BITS > OUT_POS_BITS) ? POSITION_BITS : OUT_POS_BITS;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LENGTH = 2'd2;

   typedef logic [CHAR_BITS-1:0] char_type;
   typedef logic [PATTERN_MAX-1:0][CHAR_BITS-1:0] bytes_type;
   typedef logic [LEN_BITS-1:0] len_type;

endpackage

// File: design/ss_window_cmp.sv
// parallel compare of the text window against the active pattern bytes
module ss_window_cmp
   import ss_pkg::*;
(
   input  bytes_type window,
   input  bytes_type pattern,
   input  len_type   len,
   output logic      equal
);

   // window[k] is the text byte k places back; it lines up with pattern byte len-1-k
   always_comb begin
      logic [PATTERN_MAX-1:0] ok;
      len_type                sel;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         sel = len - LEN_BITS'(k) - LEN_BITS'(1);
         if (LEN_BITS'(k) < len) begin
            ok[k] = (pattern[sel[IDX_BITS-1:0]] == window[k]);
         end else begin
            ok[k] = 1'b1;
         end
      end
      equal = &ok;
   end

endmodule

// File: design/substring_search_core.sv
// substring search core: streaming first-match search of a short pattern
// a word accepted goes into the input register, and its result into the result register once that is free
// throughput: one text word per cycle while the result side does not stall; the window compare is combinational
// the input register is freed whenever the result register is empty or being taken
// reset (synchronous, active high) clears pattern registers, history, count and valids
// an empty pattern matches at position 1; no result pending is lost across stalls
module substring_search_core
   import ss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CHAR_BITS-1:0]     req_text_char,
   input  logic                     req_last_of_text,
   input  logic                     req_empty_text,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OUT_POS_BITS-1:0]  rsp_match_position,
   output logic                     rsp_found,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [PATTERN_BITS-1:0]  csr_data
);

   localparam logic [POSITION_BITS-1:0] POS_LIMIT   = '1;
   localparam logic [POS_EXT_BITS-1:0]  OUT_POS_MAX = POS_EXT_BITS'({OUT_POS_BITS{1'b1}});

   // configuration
   logic [PATTERN_BITS-1:0] pat_low_ff,  pat_low_in;
   logic [PATTERN_BITS-1:0] pat_high_ff, pat_high_in;
   logic [PLEN_BITS-1:0]    plen_ff,     plen_in;

   // input register
   logic                    in_valid_ff, in_valid_in;
   char_type                in_char_ff,  in_char_in;
   logic                    in_last_ff,  in_last_in;
   logic                    in_empty_ff, in_empty_in;

   // text state
   char_type                hist_ff [HIST_DEPTH];
   char_type                hist_in [HIST_DEPTH];
   logic [POSITION_BITS-1:0] count_ff, count_in;
   logic                    reported_ff, reported_in;

   // result register
   logic                    out_valid_ff, out_valid_in;
   logic [OUT_POS_BITS-1:0] out_pos_ff,   out_pos_in;
   logic                    out_found_ff, out_found_in;

   logic                    out_free;
   logic                    advance;
   logic                    req_take;
   len_type                 len;
   bytes_type               window;
   bytes_type               pattern;
   logic                    window_eq;
   logic [POSITION_BITS-1:0] count_next;
   logic                    hit;
   logic                    emit;
   logic [POSITION_BITS-1:0] pos_full;
   logic [POS_EXT_BITS-1:0] pos_ext;

   assign csr_ready = 1'b1;

   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      plen_in     = plen_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pat_low_in  = csr_data;
            CSR_PATTERN_HIGH:   pat_high_in = csr_data;
            CSR_PATTERN_LENGTH: plen_in     = csr_data[PLEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      in_empty_in = in_empty_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_char_in  = req_text_char;
         in_last_in  = req_last_of_text;
         in_empty_in = req_empty_text;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // active pattern length, clamped to the window size
   assign len = (PLEN_BITS'(PATTERN_MAX) < plen_ff) ? LEN_BITS'(PATTERN_MAX)
                                                    : LEN_BITS'(plen_ff);

   // byte 0 sits in the lowest bits of the low register
   assign pattern = {pat_high_ff, pat_low_ff};

   always_comb begin
      window[0] = in_char_ff;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         window[k] = hist_ff[k-1];
      end
   end

   ss_window_cmp u_cmp (
      .window  (window),
      .pattern (pattern),
      .len     (len),
      .equal   (window_eq)
   );

   assign count_next = (count_ff == POS_LIMIT) ? count_ff : count_ff + POSITION_BITS'(1);

   assign hit = !reported_ff &&
                ((len == '0) || ((count_next >= POSITION_BITS'(len)) && window_eq));

   assign pos_full = (len == '0)              ? POSITION_BITS'(1) :
                     (count_next == POS_LIMIT) ? POS_LIMIT :
                     count_next - POSITION_BITS'(len) + POSITION_BITS'(1);
   assign pos_ext  = POS_EXT_BITS'(pos_full);

   assign emit = in_empty_ff || hit || (in_last_ff && !reported_ff);

   always_comb begin
      hist_in     = hist_ff;
      count_in    = count_ff;
      reported_in = reported_ff;
      if (advance) begin
         if (in_empty_ff || in_last_ff) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
               hist_in[k] = '0;
            end
            count_in    = '0;
            reported_in = 1'b0;
         end else begin
            for (int k = 1; k < HIST_DEPTH; k++) begin
               hist_in[k] = hist_ff[k-1];
            end
            hist_in[0]  = in_char_ff;
            count_in    = count_next;
            reported_in = reported_ff || hit;
         end
      end
   end

   always_comb begin
      out_valid_in = out_free ? (advance && emit) : out_valid_ff;
      out_pos_in   = out_pos_ff;
      out_found_in = out_found_ff;
      if (advance) begin
         if (in_empty_ff) begin
            out_found_in = (len == '0);
            out_pos_in   = OUT_POS_BITS'(len == '0);
         end else if (hit) begin
            out_found_in = 1'b1;
            out_pos_in   = (pos_ext > OUT_POS_MAX) ? OUT_POS_MAX[OUT_POS_BITS-1:0]
                                                   : pos_ext[OUT_POS_BITS-1:0];
         end else begin
            out_found_in = 1'b0;
            out_pos_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         plen_ff      <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         reported_ff  <= 1'b0;
         for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         pat_low_ff   <= pat_low_in;
         pat_high_ff  <= pat_high_in;
         plen_ff      <= plen_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         reported_ff  <= reported_in;
         hist_ff      <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff   <= in_char_in;
      in_last_ff   <= in_last_in;
      in_empty_ff  <= in_empty_in;
      out_pos_ff   <= out_pos_in;
      out_found_ff <= out_found_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_match_position = out_pos_ff;
   assign rsp_found          = out_found_ff;

   // a miss always reports position zero
   a_miss_pos_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_found_ff |-> out_pos_ff == '0)
      else $error("miss result with nonzero position");

   // a hit never reports position zero
   a_hit_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_found_ff |-> out_pos_ff != '0)
      else $error("hit result with zero position");

   // the input side only stalls while holding a word
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");

   // a reported text has seen at least one byte
   a_reported_count: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> count_ff != '0)
      else $error("reported flag set with zero count");

   // a held result stays put while stalled
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(out_pos_ff) && $stable(out_found_ff))
      else $error("stalled result changed");

endmodule

// File: tb/substring_search_checker.sv
// checker for the substring search core: predicts each text's report and compares it
module substring_search_checker
   import ss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [CHAR_BITS-1:0]     req_text_char,
   input  logic                     req_last_of_text,
   input  logic                     req_empty_text,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [OUT_POS_BITS-1:0]  rsp_match_position,
   input  logic                     rsp_found,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [PATTERN_BITS-1:0]  csr_data,
   output int                       mismatches,
   output int                       outstanding
);

   typedef struct packed {
      logic [OUT_POS_BITS-1:0] position;
      logic                    found;
   } search_report_type;

   localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;
   localparam logic [POS_EXT_BITS-1:0]  OUT_MAX   = {OUT_POS_BITS{1'b1}};

   bytes_type                pattern_bytes;
   logic [PLEN_BITS-1:0]     pattern_len;
   logic [CHAR_BITS-1:0]     history [HIST_DEPTH];
   logic [POSITION_BITS-1:0] char_count;
   logic                     reported;
   search_report_type        expected_reports [$];
   search_report_type        oldest;
   int                       fail_total;

   function automatic void clear_text();
      for (int i = 0; i < HIST_DEPTH; i++) history[i] = '0;
      char_count = '0;
      reported   = 1'b0;
   endfunction

   // one text word through the window compare; queues the report it causes, if any
   task automatic search_word(input logic [CHAR_BITS-1:0] ch, input logic last,
                              input logic empty);
      int unsigned             len;
      logic                    hit;
      logic [POS_EXT_BITS-1:0] pos;
      search_report_type       report;
      len = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : pattern_len;
      hit = 1'b0;
      pos = '0;
      if (empty) begin
         clear_text();
         report.position = (len == 0) ? OUT_POS_BITS'(1) : '0;
         report.found    = (len == 0);
         expected_reports.push_back(report);
      end else begin
         if (char_count != COUNT_MAX) char_count = char_count + 1'b1;
         if (!reported) begin
            if (len == 0) begin
               hit = 1'b1;
               pos = POS_EXT_BITS'(1);
            end else if (char_count >= len) begin
               // newest byte against the pattern tail, history against the rest
               hit = (pattern_bytes[len - 1] == ch);
               for (int k = 1; k < len; k++)
                  if (pattern_bytes[len - 1 - k] != history[k - 1]) hit = 1'b0;
               pos = (char_count == COUNT_MAX) ? POS_EXT_BITS'(COUNT_MAX)
                                               : POS_EXT_BITS'(char_count - len + 1);
            end
         end
         if (hit) begin
            report.position = (pos > OUT_MAX) ? {OUT_POS_BITS{1'b1}} : pos[OUT_POS_BITS-1:0];
            report.found    = 1'b1;
            expected_reports.push_back(report);
            reported = 1'b1;
         end else if (last && !reported) begin
            report = '0;
            expected_reports.push_back(report);
         end
         if (last) begin
            clear_text();
         end else begin
            for (int k = HIST_DEPTH - 1; k > 0; k--) history[k] = history[k - 1];
            history[0] = ch;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_text();
         pattern_bytes = '0;
         pattern_len   = '0;
         expected_reports.delete();
         fail_total    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected report: position %0d found %0b", $time,
                        rsp_match_position, rsp_found);
               fail_total++;
            end else begin
               oldest = expected_reports.pop_front();
               if (rsp_match_position !== oldest.position) begin
                  $display("%0t: match_position expected %0d actual %0d", $time,
                           oldest.position, rsp_match_position);
                  fail_total++;
               end
               if (rsp_found !== oldest.found) begin
                  $display("%0t: found expected %0b actual %0b", $time,
                           oldest.found, rsp_found);
                  fail_total++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LOW:    pattern_bytes[7:0]  = csr_data;
               CSR_PATTERN_HIGH:   pattern_bytes[15:8] = csr_data;
               CSR_PATTERN_LENGTH: pattern_len         = csr_data[PLEN_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            search_word(req_text_char, req_last_of_text, req_empty_text);
      end
      mismatches  <= fail_total;
      outstanding <= expected_reports.size();
   end

endmodule

// File: tb/tb_substring_search_core.sv
// testbench top for the substring search core: text and pattern stimulus, verdict
module tb_substring_search_core;
   import ss_pkg::*;

   localparam int HALF_HIGH      = 6;
   localparam int HALF_LOW       = 6;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_WORDS   = 1350;
   localparam int CONFIG_PHASES  = 8;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [CHAR_BITS-1:0]     req_text_char = '0;
   logic                     req_last_of_text = 1'b0;
   logic                     req_empty_text = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [OUT_POS_BITS-1:0]  rsp_match_position;
   logic                     rsp_found;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [PATTERN_BITS-1:0]  csr_data = '0;
   int                       mismatches;
   int                       outstanding;

   int                       send_idle_pct = 0;
   int                       stall_pct = 0;
   int                       idle_cycles = 0;
   int                       words_sent = 0;
   bytes_type                pattern = '0;
   int unsigned              pattern_span = 0;
   logic [CHAR_BITS-1:0]     alphabet [3];

   substring_search_core    u_top (.*);
   substring_search_checker u_checker (.*);

   always begin
      #HALF_LOW  clock = 1'b1;
      #HALF_HIGH clock = 1'b0;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // ends the run when no word moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(input logic [CHAR_BITS-1:0] ch, input logic last,
                            input logic empty);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_text_char    <= ch;
      req_last_of_text <= last;
      req_empty_text   <= empty;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [PATTERN_BITS-1:0] data, input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (!more) csr_valid <= 1'b0;
   endtask

   // wait for every report, then let words that cause none drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_pattern(input bytes_type bytes, input logic [PLEN_BITS-1:0] length);
      logic [PATTERN_BITS-1:0] len_word;
      len_word = {$urandom, $urandom};
      if ($urandom_range(1)) len_word = '0;
      len_word[PLEN_BITS-1:0] = length;
      pattern      = bytes;
      pattern_span = (length > PATTERN_MAX) ? PATTERN_MAX : length;
      csr_write(CSR_PATTERN_LOW, bytes[7:0], 1'b1);
      csr_write(CSR_PATTERN_HIGH, bytes[15:8], 1'b1);
      csr_write(CSR_PATTERN_LENGTH, len_word, 1'b0);
   endtask

   function automatic logic [CHAR_BITS-1:0] pick_char();
      if ($urandom_range(9) == 0) return CHAR_BITS'($urandom);
      return alphabet[$urandom_range(2)];
   endfunction

   // a text mostly from the alphabet, maybe with the pattern planted, maybe cut short by an empty word
   task automatic send_text(input int unsigned n, input bit plant, input bit abandon);
      logic [CHAR_BITS-1:0] chars [$];
      int unsigned          at;
      int unsigned          cut;
      for (int i = 0; i < n; i++) chars.push_back(pick_char());
      if (plant && pattern_span != 0 && n >= pattern_span) begin
         at = $urandom_range(n - pattern_span);
         for (int k = 0; k < pattern_span; k++) chars[at + k] = pattern[k];
      end
      cut = abandon ? $urandom_range(n - 1) : n;
      for (int i = 0; i < cut; i++) send_word(chars[i], i == n - 1, 1'b0);
      if (abandon) send_word(CHAR_BITS'($urandom), 1'($urandom_range(1)), 1'b1);
   endtask

   initial begin
      bytes_type            bytes;
      logic [PLEN_BITS-1:0] length;
      int unsigned          pick;
      int unsigned          n;
      int                   phase_end;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty pattern: hit on the first byte, later bytes and the last stay silent; an empty text then hits at 1
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'h5A, 1'b1, 1'b0);
      send_word(8'hFF, 1'b1, 1'b1);
      settle();

      // oversized length clamps to a full 16-byte window
      load_pattern('1, PLEN_BITS'(31));
      send_word(8'h00, 1'b0, 1'b0);
      for (int i = 0; i < PATTERN_MAX; i++) send_word(8'hFF, i == PATTERN_MAX - 1, 1'b0);
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      settle();

      // length change in the middle of a text
      load_pattern({112'h0, 16'h4241}, PLEN_BITS'(2));
      send_word(8'h41, 1'b0, 1'b0);
      settle();
      csr_write(CSR_PATTERN_LENGTH, PATTERN_BITS'(1), 1'b0);
      send_word(8'h42, 1'b0, 1'b0);
      send_word(8'h41, 1'b1, 1'b0);
      send_word(8'h41, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      settle();
      csr_write(CSR_UNUSED, {$urandom, $urandom}, 1'b0);

      for (int phase = 0; phase < CONFIG_PHASES; phase++) begin
         settle();
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 65; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
         endcase
         for (int i = 0; i < 3; i++) alphabet[i] = CHAR_BITS'($urandom);
         for (int i = 0; i < PATTERN_MAX; i++) bytes[i] = CHAR_BITS'($urandom);
         pick = $urandom_range(9);
         if (pick == 0) length = '0;
         else if (pick == 1) length = PLEN_BITS'(PATTERN_MAX);
         else if (pick == 2) length = PLEN_BITS'($urandom_range(PATTERN_MAX + 1, 31));
         else length = PLEN_BITS'($urandom_range(1, 6));
         for (int i = 0; i < PATTERN_MAX; i++)
            if (i < length) bytes[i] = alphabet[$urandom_range(2)];
         load_pattern(bytes, length);

         phase_end = words_sent + RANDOM_WORDS / CONFIG_PHASES;
         while (words_sent < phase_end) begin
            pick = $urandom_range(99);
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 60)
                                         : $urandom_range(1, pattern_span + 12);
            if (pick < 6)
               send_word(CHAR_BITS'($urandom), 1'($urandom_range(1)), 1'b1);
            else
               send_text(n, 1'($urandom_range(1)), pick < 10);
         end
      end

      settle();
      if (mismatches == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
